// ===== sv/tlem_pkg.sv =====
package tlem_pkg;

    localparam int LOG_KEY_BITS_DEF = 16;
    localparam int EXP_KEY_BITS_DEF = 10;
    localparam int EXP_RANGES_DEF   = 42;

    localparam int VAL_W   = 32;
    localparam int RNG_W   = 6;
    localparam int ENTRY_W = VAL_W + RNG_W;
    localparam int IDX_W   = 16;

    typedef enum logic [2:0] {
        OP_WR_LOG = 3'd0,
        OP_WR_EXP = 3'd1,
        OP_ADD    = 3'd2,
        OP_LOG    = 3'd3,
        OP_EXP    = 3'd4,
        OP_MUL    = 3'd5,
        OP_NOP6   = 3'd6,
        OP_NOP7   = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_SIGN  = 2'd1,
        ST_RANGE = 2'd2,
        ST_RSVD  = 2'd3
    } status_t;

    // value, range, status
    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [RNG_W-1:0]        range;
        status_t                 status;
    } num_t;

    // Range-aligning add.
    function automatic num_t add_nums(input logic signed [VAL_W-1:0] av,
                                      input logic [RNG_W-1:0] ar,
                                      input logic signed [VAL_W-1:0] bv,
                                      input logic [RNG_W-1:0] br);
        logic signed [VAL_W-1:0] hv, lv;
        logic [RNG_W-1:0]        hr, d;
        logic signed [VAL_W:0]   lo_al, hi_ex, sum;
        num_t                    n;
        if (br > ar) begin
            hv = bv; hr = br; lv = av; d = br - ar;
        end else begin
            hv = av; hr = ar; lv = bv; d = ar - br;
        end
        hi_ex = $signed({hv[VAL_W-1], hv});
        lo_al = $signed({lv[VAL_W-1], lv}) >>> d;
        sum   = lo_al + hi_ex;
        n = '0;
        if (sum[VAL_W] != sum[VAL_W-1]) begin
            if (hr == '1) begin
                n.status = ST_RANGE;
            end else begin
                // on overflow, sum the halved operands and step the range up by one
                n.value = VAL_W'((lo_al >>> 1) + (hi_ex >>> 1));
                n.range = hr + RNG_W'(1);
            end
        end else begin
            n.value = sum[VAL_W-1:0];
            n.range = hr;
        end
        return n;
    endfunction

endpackage

// ===== sv/tlem_log_front.sv =====
// Leading-one search and key extraction for log2; integer part conversion.
module tlem_log_front #(
    parameter int LOG_KEY_BITS = tlem_pkg::LOG_KEY_BITS_DEF
) (
    input  logic signed [31:0]      m,
    input  logic [5:0]              r,
    output logic [LOG_KEY_BITS-1:0] key,
    output logic                    bad,
    output logic signed [31:0]      ip_value,
    output logic [5:0]              ip_range
);
    import tlem_pkg::*;

    logic [5:0]         p;
    logic [5:0]         s;
    logic signed [7:0]  k;
    logic [6:0]         mag;
    logic [5:0]         q;
    logic signed [63:0] prod;

    always_comb begin
        p = '0;
        for (int i = 0; i < 32; i++) begin
            if (m[i]) p = 6'(i + 1);
        end
        s   = (p > 6'(LOG_KEY_BITS)) ? p - 6'(LOG_KEY_BITS) : '0;
        key = LOG_KEY_BITS'(32'(m) >> s);
        bad = (m <= 0);
        k   = 8'(s) + 8'(r) - 8'sd31;
        mag = k[7] ? 7'(-k) : 7'(k);
        q = '0;
        for (int i = 30; i >= 0; i--) begin
            if ((64'd1 << i) >= 64'(mag)) q = 6'(i);
        end
        if (64'(mag) > (64'd1 << 31)) q = 6'd31;
        prod = 64'(k) <<< (6'd31 - q);
        if (k == 0) begin
            ip_value = '0; ip_range = '0;
        end else begin
            ip_value = (prod > 64'sh7fffffff) ? 32'sh7fffffff : prod[31:0];
            ip_range = q;
        end
    end
endmodule

// ===== sv/tlem_log_mem.sv =====
module tlem_log_mem #(
    parameter int LOG_KEY_BITS = tlem_pkg::LOG_KEY_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    we,
    input  logic [LOG_KEY_BITS-1:0] waddr,
    input  logic [tlem_pkg::ENTRY_W-1:0] wdata,
    input  logic                    re0,
    input  logic [LOG_KEY_BITS-1:0] raddr0,
    output logic [tlem_pkg::ENTRY_W-1:0] rdata0,
    input  logic                    re1,
    input  logic [LOG_KEY_BITS-1:0] raddr1,
    output logic [tlem_pkg::ENTRY_W-1:0] rdata1
);
    import tlem_pkg::*;

    logic [ENTRY_W-1:0] mem [2**LOG_KEY_BITS];

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        if (re0) rdata0 <= mem[raddr0];
        if (re1) rdata1 <= mem[raddr1];
    end
endmodule

// ===== sv/tlem_exp_mem.sv =====
module tlem_exp_mem #(
    parameter int AW = 16
) (
    input  logic                 aclk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  logic [tlem_pkg::ENTRY_W-1:0] wdata,
    input  logic                 re,
    input  logic [AW-1:0]        raddr,
    output logic [tlem_pkg::ENTRY_W-1:0] rdata
);
    import tlem_pkg::*;

    logic [ENTRY_W-1:0] mem [2**AW];

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        if (re) rdata <= mem[raddr];
    end
endmodule

// ===== sv/table_log_exp_multiplier_unit.sv =====
// Channel | Direction | tdata (low bit up)                              | tuser
// s_axis  | in        | a_value, a_range, b_value, b_range,             | op
//         |           | table_index, table_column (98 bits in 104)      |
// m_axis  | out       | result_value, result_range (38 bits in 40)      | status
//
// Pipeline of four register stages, one transaction per cycle while m_axis is not
// stalled. The stage rate is set by the log table port pair and the exp table read
// port; each is read once per item.
// Log writes enter in the first stage beside the log reads, exp writes in the
// third stage beside the exp read, so each table sees transactions in order.
// aresetn clears the valid bits only; the tables hold no reset value.
// A stall on m_axis holds all stages; s_tready is high while m_tready is high or m_tvalid is low.
module table_log_exp_multiplier_unit #(
    parameter int LOG_KEY_BITS = tlem_pkg::LOG_KEY_BITS_DEF,
    parameter int EXP_KEY_BITS = tlem_pkg::EXP_KEY_BITS_DEF,
    parameter int EXP_RANGES   = tlem_pkg::EXP_RANGES_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [103:0]  s_tdata,   // a_value, a_range, b_value, b_range, table_index, table_column
    input  logic [2:0]    s_tuser,   // op
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [39:0]   m_tdata,   // result_value, result_range
    output logic [1:0]    m_tuser    // status
);
    import tlem_pkg::*;

    localparam int EXP_AW = $clog2(EXP_RANGES << EXP_KEY_BITS);

    logic        adv;
    logic        v1_reg, v2_reg, v3_reg, v4_reg;
    op_t         op_in;
    logic signed [31:0] av, bv;
    logic [5:0]  ar, br, col;
    logic [15:0] idx;

    assign op_in = op_t'(s_tuser);
    assign av  = s_tdata[31:0];
    assign ar  = s_tdata[37:32];
    assign bv  = s_tdata[69:38];
    assign br  = s_tdata[75:70];
    assign idx = s_tdata[91:76];
    assign col = s_tdata[97:92];

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;
    wire   acc      = s_tvalid && s_tready;

    // stage 1: decode, write log table, issue log reads
    logic [LOG_KEY_BITS-1:0] ka, kb;
    logic bad_a, bad_b;
    logic signed [31:0] ipa_v, ipb_v;
    logic [5:0] ipa_r, ipb_r;

    tlem_log_front #(.LOG_KEY_BITS(LOG_KEY_BITS)) u_fa (
        .m(av), .r(ar), .key(ka), .bad(bad_a), .ip_value(ipa_v), .ip_range(ipa_r));
    tlem_log_front #(.LOG_KEY_BITS(LOG_KEY_BITS)) u_fb (
        .m(bv), .r(br), .key(kb), .bad(bad_b), .ip_value(ipb_v), .ip_range(ipb_r));

    logic log_ok, exp_ok;
    assign log_ok = (32'(idx) < (32'd1 << LOG_KEY_BITS));
    assign exp_ok = (32'(idx) < (32'd1 << EXP_KEY_BITS)) && (32'(col) < 32'(EXP_RANGES));

    logic [EXP_AW-1:0] waddr;
    assign waddr = EXP_AW'(32'(idx[EXP_KEY_BITS-1:0]) * 32'(EXP_RANGES) + 32'(col));

    logic [ENTRY_W-1:0] la_q, lb_q;
    tlem_log_mem #(.LOG_KEY_BITS(LOG_KEY_BITS)) u_log (
        .aclk(aclk),
        .we(acc && op_in == OP_WR_LOG && log_ok),
        .waddr(idx[LOG_KEY_BITS-1:0]), .wdata({ar, av}),
        .re0(adv), .raddr0(ka), .rdata0(la_q),
        .re1(adv), .raddr1(kb), .rdata1(lb_q));

    op_t  op1_reg;
    logic bad_a1_reg, bad_b1_reg, werr1_reg;
    logic signed [31:0] av1_reg, bv1_reg, ipa1_v_reg, ipb1_v_reg;
    logic [5:0] ar1_reg, br1_reg, ipa1_r_reg, ipb1_r_reg;
    logic wexp1_reg;
    logic [EXP_AW-1:0] wad1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= acc;
        end
        if (adv) begin
            op1_reg    <= op_in;
            bad_a1_reg <= bad_a;
            bad_b1_reg <= bad_b;
            werr1_reg  <= (op_in == OP_WR_LOG) ? !log_ok : !exp_ok;
            av1_reg <= av; ar1_reg <= ar; bv1_reg <= bv; br1_reg <= br;
            ipa1_v_reg <= ipa_v; ipa1_r_reg <= ipa_r;
            ipb1_v_reg <= ipb_v; ipb1_r_reg <= ipb_r;
            wexp1_reg  <= (op_in == OP_WR_EXP) && exp_ok;
            wad1_reg   <= waddr;
        end
    end

    // stage 2: log results and add
    num_t lga, lgb, sum2;
    always_comb begin
        lga = add_nums(ipa1_v_reg, ipa1_r_reg, la_q[31:0], la_q[37:32]);
        lgb = add_nums(ipb1_v_reg, ipb1_r_reg, lb_q[31:0], lb_q[37:32]);
        if (bad_a1_reg) lga = '{value: '0, range: '0, status: ST_SIGN};
        if (bad_b1_reg) lgb = '{value: '0, range: '0, status: ST_SIGN};
        sum2 = '0;
        case (op1_reg)
            OP_WR_LOG, OP_WR_EXP:
                sum2.status = werr1_reg ? ST_RANGE : ST_OK;
            OP_ADD: sum2 = add_nums(av1_reg, ar1_reg, bv1_reg, br1_reg);
            OP_LOG: sum2 = lga;
            OP_EXP: begin
                sum2.value = av1_reg;
                sum2.range = ar1_reg;
            end
            OP_MUL: begin
                if (lga.status != ST_OK) sum2 = lga;
                else if (lgb.status != ST_OK) sum2 = lgb;
                else sum2 = add_nums(lga.value, lga.range, lgb.value, lgb.range);
            end
            default: sum2 = '0;
        endcase
    end

    op_t  op2_reg;
    num_t n2_reg;
    logic wexp2_reg;
    logic [EXP_AW-1:0] wad2_reg;
    logic [ENTRY_W-1:0] wdat2_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg;
        end
        if (adv) begin
            op2_reg   <= op1_reg;
            n2_reg    <= sum2;
            wexp2_reg <= wexp1_reg;
            wad2_reg  <= wad1_reg;
            wdat2_reg <= {ar1_reg, av1_reg};
        end
    end

    // stage 3: exp address, read and write
    logic do_exp, exp_neg, exp_col;
    logic [EXP_KEY_BITS-1:0] row;
    logic [EXP_AW-1:0] raddr;
    assign do_exp  = (op2_reg == OP_EXP || op2_reg == OP_MUL) && n2_reg.status == ST_OK;
    assign exp_neg = n2_reg.value < 0;
    assign exp_col = 32'(n2_reg.range) >= 32'(EXP_RANGES);
    assign row     = n2_reg.value[30 -: EXP_KEY_BITS];
    assign raddr   = EXP_AW'(32'(row) * 32'(EXP_RANGES) + 32'(n2_reg.range));

    logic [ENTRY_W-1:0] ex_q;
    tlem_exp_mem #(.AW(EXP_AW)) u_exp (
        .aclk(aclk),
        .we(adv && v2_reg && wexp2_reg),
        .waddr(wad2_reg), .wdata(wdat2_reg),
        .re(adv), .raddr(raddr), .rdata(ex_q));

    logic use_q3_reg;
    num_t n3_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (adv) begin
            v3_reg <= v2_reg;
        end
        if (adv) begin
            use_q3_reg <= do_exp && !exp_neg && !exp_col;
            if (do_exp && exp_neg)
                n3_reg <= '{value: '0, range: '0, status: ST_SIGN};
            else if (do_exp && exp_col)
                n3_reg <= '{value: '0, range: '0, status: ST_RANGE};
            else
                n3_reg <= n2_reg;
        end
    end

    // stage 4: output register
    num_t out_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (adv) begin
            v4_reg <= v3_reg;
        end
        if (adv) begin
            out_reg <= use_q3_reg ? num_t'{value: ex_q[31:0], range: ex_q[37:32], status: ST_OK}
                                  : n3_reg;
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = {2'b00, out_reg.range, out_reg.value};
    assign m_tuser  = out_reg.status;

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output changed under stall");
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_OK |-> m_tdata == '0)
        else $error("nonzero payload with error status");
    a_no_rsvd: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser != ST_RSVD)
        else $error("reserved status");
endmodule

// ===== tb/sv/table_log_exp_multiplier_unit_tb.sv =====
`timescale 1ns / 1ps

module table_log_exp_multiplier_unit_tb;
    import tlem_pkg::*;

    localparam int LOG_KEYS   = 65536;
    localparam int EXP_ROWS   = 1024;
    localparam int EXP_COLS   = 42;
    localparam int MAX_CYCLES = 1000000;

    typedef struct {
        longint v;
        int     r;
        int     st;
    } lnum_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [103:0] s_tdata = '0;
    logic [2:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [39:0]  m_tdata;
    logic [1:0]   m_tuser;

    logic [37:0] log_mem [LOG_KEYS];
    bit          log_wr  [LOG_KEYS];
    logic [37:0] exp_mem [EXP_ROWS][EXP_COLS];
    bit          exp_wr  [EXP_ROWS][EXP_COLS];

    lnum_t  pending_results[$];
    bit     failed = 0;
    int     cycle_count = 0;
    int     rx_hold = 0;
    bit     rx_fast = 0;
    bit     tx_fast = 0;

    table_log_exp_multiplier_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ---------------- predictor ----------------
    function automatic lnum_t mk(longint v, int r, int st);
        lnum_t n;
        n.v = st ? 0 : v;
        n.r = st ? 0 : r;
        n.st = st;
        return n;
    endfunction

    function automatic longint asr_l(longint x, int s);
        if (s > 62) s = 62;
        return x >>> s;
    endfunction

    function automatic lnum_t entry_num(logic [37:0] e);
        return mk(longint'($signed(e[31:0])), int'(e[37:32]), 0);
    endfunction

    function automatic lnum_t aligned_add(lnum_t a, lnum_t b);
        lnum_t  hi, lo;
        int     d;
        longint sum;
        hi = (b.r > a.r) ? b : a;
        lo = (b.r > a.r) ? a : b;
        d = hi.r - lo.r;
        sum = asr_l(lo.v, d) + hi.v;
        if (sum > 64'sd2147483647 || sum < -64'sd2147483648) begin
            if (hi.r + 1 > 63) return mk(0, 0, ST_RANGE);
            return mk(asr_l(lo.v, d + 1) + asr_l(hi.v, 1), hi.r + 1, ST_OK);
        end
        return mk(sum, hi.r, ST_OK);
    endfunction

    function automatic lnum_t int_to_num(longint k);
        longint mag, v;
        int     q;
        mag = (k < 0) ? -k : k;
        q = 0;
        if (k == 0) return mk(0, 0, ST_OK);
        while (q < 31 && (64'sd1 <<< q) < mag) q++;
        v = k * (64'sd1 <<< (31 - q));
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        return mk(v, q, ST_OK);
    endfunction

    function automatic int log_key(longint v, output int s);
        logic [31:0] m;
        int          p;
        m = v[31:0];
        p = 0;
        while (p < 32 && (m >> p) != 0) p++;
        s = (p > 16) ? p - 16 : 0;
        return int'((m >> s) & 32'hffff);
    endfunction

    function automatic lnum_t log2_num(lnum_t a);
        int s, key;
        if (a.v <= 0) return mk(0, 0, ST_SIGN);
        key = log_key(a.v, s);
        return aligned_add(int_to_num(longint'(s + a.r - 31)), entry_num(log_mem[key]));
    endfunction

    function automatic int exp_row(longint v);
        logic [31:0] m;
        m = v[31:0];
        return int'((m >> 21) & 32'h3ff);
    endfunction

    function automatic lnum_t exp2_num(lnum_t a);
        if (a.v < 0) return mk(0, 0, ST_SIGN);
        if (a.r >= EXP_COLS) return mk(0, 0, ST_RANGE);
        return entry_num(exp_mem[exp_row(a.v)][a.r]);
    endfunction

    // Update table state and return the expected answer of one transaction.
    function automatic lnum_t unit_result(op_t op, logic [31:0] av, logic [5:0] ar,
                                          logic [31:0] bv, logic [5:0] br,
                                          logic [15:0] idx, logic [5:0] col);
        lnum_t a, b, la, lb, res;
        a = mk(longint'($signed(av)), int'(ar), 0);
        b = mk(longint'($signed(bv)), int'(br), 0);
        res = mk(0, 0, ST_OK);
        case (op)
            OP_WR_LOG: begin
                log_mem[idx] = {ar, av};
                log_wr[idx] = 1;
            end
            OP_WR_EXP: begin
                if (idx < EXP_ROWS && col < EXP_COLS) begin
                    exp_mem[idx][col] = {ar, av};
                    exp_wr[idx][col] = 1;
                end else begin
                    res = mk(0, 0, ST_RANGE);
                end
            end
            OP_ADD: res = aligned_add(a, b);
            OP_LOG: res = log2_num(a);
            OP_EXP: res = exp2_num(a);
            OP_MUL: begin
                la = log2_num(a);
                lb = log2_num(b);
                if (la.st != 0) res = la;
                else if (lb.st != 0) res = lb;
                else begin
                    res = aligned_add(la, lb);
                    if (res.st == 0) res = exp2_num(res);
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // ---------------- driving ----------------
    function automatic int gap_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (tx_fast || pick < 60) return 0;
        if (pick < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    task automatic send_item(op_t op, logic [31:0] av, logic [5:0] ar,
                             logic [31:0] bv, logic [5:0] br,
                             logic [15:0] idx, logic [5:0] col);
        int gap;
        bit ready;
        gap = gap_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'd0, col, idx, br, bv, ar, av};
        pending_results.push_back(unit_result(op, av, ar, bv, br, idx, col));
        // sample ready between edges, where it is settled
        do begin
            @(negedge aclk);
            ready = s_tready;
            @(posedge aclk);
        end while (!ready);
    endtask

    function automatic logic [31:0] rand_value();
        int pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'(int'($urandom_range(0, 255)) - 128);
            3: return 32'd0;
            default: return $urandom;
        endcase
    endfunction

    // Write a table entry before any read of it, so no read hits an unwritten entry.
    task automatic fill_log_key(logic [31:0] v);
        int s, key;
        if ($signed(v) > 0) begin
            key = log_key(longint'($signed(v)), s);
            if (!log_wr[key])
                send_item(OP_WR_LOG, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 4000),
                          6'($urandom_range(0, 8)), 0, 0, 16'(key), 0);
        end
    endtask

    task automatic fill_exp_entry(lnum_t x);
        int row;
        if (x.st == 0 && x.v >= 0 && x.r < EXP_COLS) begin
            row = exp_row(x.v);
            if (!exp_wr[row][x.r])
                send_item(OP_WR_EXP, rand_value(), 6'($urandom),
                          0, 0, 16'(row), 6'(x.r));
        end
    endtask

    task automatic do_log(logic [31:0] av, logic [5:0] ar);
        fill_log_key(av);
        send_item(OP_LOG, av, ar, $urandom, 6'($urandom), 16'($urandom), 6'($urandom));
    endtask

    task automatic do_exp(logic [31:0] av, logic [5:0] ar);
        fill_exp_entry(mk(longint'($signed(av)), int'(ar), 0));
        send_item(OP_EXP, av, ar, $urandom, 6'($urandom), 16'($urandom), 6'($urandom));
    endtask

    task automatic do_mul(logic [31:0] av, logic [5:0] ar, logic [31:0] bv, logic [5:0] br);
        lnum_t la, lb;
        fill_log_key(av);
        fill_log_key(bv);
        la = log2_num(mk(longint'($signed(av)), int'(ar), 0));
        lb = log2_num(mk(longint'($signed(bv)), int'(br), 0));
        if (la.st == 0 && lb.st == 0) fill_exp_entry(aligned_add(la, lb));
        send_item(OP_MUL, av, ar, bv, br, 16'($urandom), 6'($urandom));
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // ---------------- receiving and checking ----------------
    initial begin
        int stall_left;
        int pick;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (rx_hold > 0) begin
                m_tready <= 1'b0;
                rx_hold--;
            end else if (rx_fast) begin
                m_tready <= 1'b1;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 20) stall_left = $urandom_range(0, 2);
                else if (pick < 24) stall_left = $urandom_range(9, 29);
                m_tready <= (pick >= 24);
            end
        end
    end

    always @(posedge aclk) begin
        lnum_t exp_res;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result transaction with nothing expected");
                failed = 1;
            end else begin
                exp_res = pending_results.pop_front();
                if (m_tdata[31:0] !== exp_res.v[31:0]) begin
                    $error("result_value expected %h actual %h", exp_res.v[31:0], m_tdata[31:0]);
                    failed = 1;
                end
                if (m_tdata[37:32] !== 6'(exp_res.r)) begin
                    $error("result_range expected %0d actual %0d", exp_res.r, m_tdata[37:32]);
                    failed = 1;
                end
                if (m_tuser !== 2'(exp_res.st)) begin
                    $error("status expected %0d actual %0d", exp_res.st, m_tuser);
                    failed = 1;
                end
            end
        end
    end

    // ---------------- tests ----------------
    task automatic test_writes_and_nops();
        send_item(OP_WR_LOG, 32'h7fffffff, 6'd63, 0, 0, 16'h8000, 0);
        send_item(OP_WR_LOG, 32'd1000, 6'd50, 0, 0, 16'h9000, 0);
        send_item(OP_WR_LOG, 32'hfffffc18, 6'd10, 0, 0, 16'ha000, 0);
        send_item(OP_WR_LOG, 32'h80000000, 6'd0, 0, 0, 16'hffff, 0);
        send_item(OP_WR_EXP, 32'h12345678, 6'd5, 0, 0, 16'd1023, 6'd41);
        send_item(OP_WR_EXP, 32'd7, 6'd3, 0, 0, 16'd1024, 6'd0);
        send_item(OP_WR_EXP, 32'd7, 6'd3, 0, 0, 16'hffff, 6'd63);
        send_item(OP_WR_EXP, 32'd7, 6'd3, 0, 0, 16'd0, 6'd42);
        send_item(OP_NOP6, $urandom, 6'd63, $urandom, 6'd63, 16'hffff, 6'd63);
        send_item(OP_NOP7, $urandom, 6'd1, $urandom, 6'd2, 16'h1234, 6'd9);
    endtask

    task automatic test_add_edges();
        send_item(OP_ADD, 32'h7fffffff, 6'd10, 32'h7fffffff, 6'd10, 0, 0);
        send_item(OP_ADD, 32'h7fffffff, 6'd63, 32'h7fffffff, 6'd63, 0, 0);
        send_item(OP_ADD, 32'h80000000, 6'd0, 32'h80000000, 6'd0, 0, 0);
        send_item(OP_ADD, 32'h80000000, 6'd0, 32'h12345678, 6'd63, 0, 0);
        send_item(OP_ADD, 32'h00000005, 6'd63, 32'hfffffff0, 6'd1, 0, 0);
    endtask

    task automatic test_log_exp_mul_edges();
        do_log(32'd0, 6'd5);
        do_log(32'h80000000, 6'd5);
        do_log(32'd1, 6'd0);
        do_log(32'h7fffffff, 6'd63);
        do_exp(32'hffffffff, 6'd3);
        do_exp(32'd5, 6'd42);
        do_exp(32'd0, 6'd0);
        do_exp(32'h7fffffff, 6'd41);
        do_mul(32'd0, 6'd1, 32'd5, 6'd1);
        do_mul(32'd5, 6'd1, 32'hfffffffb, 6'd1);
        // key 0x8000 holds max mantissa at range 63: the sum overflows past range 63
        do_mul(32'h8000, 6'd31, 32'h8000, 6'd31);
        // key 0x9000 lands beyond the exp columns, key 0xa000 gives a negative exp operand
        do_mul(32'h9000, 6'd31, 32'h9000, 6'd31);
        do_mul(32'ha000, 6'd31, 32'ha000, 6'd31);
    endtask

    task automatic test_random(int count);
        int pick;
        for (int i = 0; i < count; i++) begin
            if (i % 150 == 0) begin
                tx_fast = ($urandom_range(0, 3) == 0);
                rx_fast = ($urandom_range(0, 3) == 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 18)
                send_item(OP_ADD, rand_value(), 6'($urandom), rand_value(), 6'($urandom),
                          16'($urandom), 6'($urandom));
            else if (pick < 36)
                do_log(rand_value(), 6'($urandom));
            else if (pick < 54)
                do_exp(rand_value(), $urandom_range(0, 9) == 0 ? 6'($urandom)
                                                               : 6'($urandom_range(0, 41)));
            else if (pick < 82)
                do_mul(rand_value(), 6'($urandom_range(0, 63)),
                       rand_value(), 6'($urandom_range(0, 63)));
            else if (pick < 89)
                send_item(OP_WR_LOG, rand_value(), 6'($urandom), $urandom, 6'($urandom),
                          16'($urandom), 6'($urandom));
            else if (pick < 96)
                send_item(OP_WR_EXP, rand_value(), 6'($urandom), $urandom, 6'($urandom),
                          $urandom_range(0, 1) ? 16'($urandom_range(0, 1023)) : 16'($urandom),
                          6'($urandom));
            else
                send_item($urandom_range(0, 1) ? OP_NOP6 : OP_NOP7, $urandom, 6'($urandom),
                          $urandom, 6'($urandom), 16'($urandom), 6'($urandom));
        end
        tx_fast = 0;
        rx_fast = 0;
    endtask

    task automatic test_backpressure();
        // hold the result side while the sender streams, filling the pipeline
        tx_fast = 1;
        rx_hold = 200;
        for (int i = 0; i < 30; i++)
            send_item(OP_ADD, rand_value(), 6'($urandom), rand_value(), 6'($urandom),
                      16'($urandom), 6'($urandom));
        tx_fast = 0;
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_writes_and_nops();
        test_add_edges();
        test_log_exp_mul_edges();
        test_backpressure();
        test_random(580);
        wait_drain();
        if (failed)
            $display("Regression FAIL");
        else
            $display("Regression PASS");
        $finish;
    end

endmodule

// ===== table_log_exp_multiplier_unit.f =====
sv/tlem_pkg.sv
sv/tlem_log_front.sv
sv/tlem_log_mem.sv
sv/tlem_exp_mem.sv
sv/table_log_exp_multiplier_unit.sv
tb/sv/table_log_exp_multiplier_unit_tb.sv
